>>> design/ipv_pkg.sv
// Shared types, constants and helper functions for the address text validator.
package ipv_pkg;

  localparam int unsigned CH_W       = 8;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned SEP_W      = 4;
  localparam int unsigned DIG_W      = 3;
  localparam int unsigned FVAL_W     = 16;
  localparam int unsigned PEND_W     = 5;
  localparam int unsigned ACC_W      = FVAL_W + 4;

  localparam logic [SEP_W-1:0]  SEP_SAT    = 4'd15;
  localparam logic [SEP_W-1:0]  V6_SEPS    = 4'd7;
  localparam logic [SEP_W-1:0]  V4_SEPS    = 4'd3;
  localparam logic [DIG_W-1:0]  DIG_SAT    = 3'd7;
  localparam logic [DIG_W-1:0]  V6_DIG_MAX = 3'd4;
  localparam logic [DIG_W-1:0]  V4_DIG_MAX = 3'd3;
  localparam logic [FVAL_W-1:0] FVAL_SAT   = 16'd65535;
  localparam logic [FVAL_W-1:0] OCTET_MAX  = 16'd255;
  localparam logic [PEND_W-1:0] PEND_SAT   = 5'd31;

  localparam logic [CH_W-1:0] CH_COLON = 8'h3A;
  localparam logic [CH_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CH_W-1:0] CH_DASH  = 8'h2D;
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CH_W-1:0] CH_LA    = 8'h61;
  localparam logic [CH_W-1:0] CH_LF    = 8'h66;
  localparam logic [CH_W-1:0] CH_UA    = 8'h41;
  localparam logic [CH_W-1:0] CH_UF    = 8'h46;

  // verdict codes
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_V4   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_V6   = 2'd2;

  typedef enum logic [1:0] {
    MODE_UNDEC = 2'd0,
    MODE_V4    = 2'd1,
    MODE_V6    = 2'd2
  } ipv_mode_t;

  typedef struct packed {
    ipv_mode_t         mode;
    logic              failed;
    logic [SEP_W-1:0]  sep_cnt;
    logic [DIG_W-1:0]  dig_cnt;
    logic [FVAL_W-1:0] fval;
    logic              lead_zero;
    logic [PEND_W-1:0] pend_cnt;
    logic              pend_hex_ok;
  } ipv_state_t;

  localparam ipv_state_t ST_RESET = '{
    mode:        MODE_UNDEC,
    failed:      1'b0,
    sep_cnt:     '0,
    dig_cnt:     '0,
    fval:        '0,
    lead_zero:   1'b0,
    pend_cnt:    '0,
    pend_hex_ok: 1'b1
  };

  function automatic logic is_dec(input logic [CH_W-1:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_hex(input logic [CH_W-1:0] c);
    return is_dec(c) || ((c >= CH_LA) && (c <= CH_LF)) || ((c >= CH_UA) && (c <= CH_UF));
  endfunction

  // one octet: 1..3 digits, no leading zero unless lone, value at most 255
  function automatic logic v4_ok(input ipv_state_t s);
    logic cnt_ok;
    cnt_ok = (s.dig_cnt != '0) && (s.dig_cnt <= V4_DIG_MAX);
    return cnt_ok && !(s.lead_zero && (s.dig_cnt > 3'd1)) && (s.fval <= OCTET_MAX);
  endfunction

  // value*10 + digit, saturating
  function automatic logic [FVAL_W-1:0] dec_accum(input logic [FVAL_W-1:0] v,
                                                  input logic [CH_W-1:0]   c);
    logic [ACC_W-1:0] sum;
    logic [CH_W-1:0]  d;
    d   = c - CH_ZERO;
    sum = ({4'b0, v} << 3) + ({4'b0, v} << 1) + ACC_W'(d);
    return (sum > ACC_W'(FVAL_SAT)) ? FVAL_SAT : sum[FVAL_W-1:0];
  endfunction

  function automatic logic [DIG_W-1:0] dig_inc(input logic [DIG_W-1:0] d);
    return (d != DIG_SAT) ? DIG_W'(d + 1'b1) : d;
  endfunction

endpackage

>>> design/ipv_step.sv
// Per-word state update and verdict logic of the address text validator.
module ipv_step
  import ipv_pkg::*;
(
  input  ipv_state_t        st,
  input  logic [CH_W-1:0]   ch,
  input  logic              last,
  output ipv_state_t        st_nxt,
  output logic [KIND_W-1:0] kind
);

  ipv_state_t       upd;
  logic [SEP_W-1:0] sep_inc;

  assign sep_inc = (st.sep_cnt != SEP_SAT) ? SEP_W'(st.sep_cnt + 1'b1) : st.sep_cnt;

  always_comb begin
    upd = st;
    unique case (st.mode)
      MODE_V6: begin
        if (ch == CH_COLON) begin
          if (st.dig_cnt == '0) upd.failed = 1'b1;
          upd.sep_cnt = sep_inc;
          if (sep_inc > V6_SEPS) upd.failed = 1'b1;
          upd.dig_cnt   = '0;
          upd.fval      = '0;
          upd.lead_zero = 1'b0;
        end else if (is_hex(ch)) begin
          upd.dig_cnt = dig_inc(st.dig_cnt);
          if (dig_inc(st.dig_cnt) > V6_DIG_MAX) upd.failed = 1'b1;
        end else begin
          upd.failed = 1'b1;
        end
      end
      MODE_V4: begin
        if (ch == CH_DOT) begin
          if (!v4_ok(st)) upd.failed = 1'b1;
          upd.sep_cnt = sep_inc;
          if (sep_inc > V4_SEPS) upd.failed = 1'b1;
          upd.dig_cnt   = '0;
          upd.fval      = '0;
          upd.lead_zero = 1'b0;
        end else if (is_dec(ch)) begin
          if (st.dig_cnt == '0) upd.lead_zero = (ch == CH_ZERO);
          upd.fval    = dec_accum(st.fval, ch);
          upd.dig_cnt = dig_inc(st.dig_cnt);
          if (dig_inc(st.dig_cnt) > V4_DIG_MAX) upd.failed = 1'b1;
        end else begin
          upd.failed = 1'b1;
        end
      end
      default: begin
        // undecided: first separator picks the type
        if (ch == CH_COLON) begin
          if ((st.pend_cnt == '0) || (st.pend_cnt > PEND_W'(V6_DIG_MAX)) || !st.pend_hex_ok)
            upd.failed = 1'b1;
          upd.mode      = MODE_V6;
          upd.sep_cnt   = SEP_W'(1);
          upd.dig_cnt   = '0;
          upd.fval      = '0;
          upd.lead_zero = 1'b0;
        end else if (ch == CH_DOT) begin
          if ((st.pend_cnt != PEND_W'(st.dig_cnt)) || !v4_ok(st)) upd.failed = 1'b1;
          upd.mode      = MODE_V4;
          upd.sep_cnt   = SEP_W'(1);
          upd.dig_cnt   = '0;
          upd.fval      = '0;
          upd.lead_zero = 1'b0;
        end else begin
          if (ch == CH_DASH) upd.failed = 1'b1;
          if (!is_hex(ch)) upd.pend_hex_ok = 1'b0;
          if (is_dec(ch)) begin
            if (st.pend_cnt == '0) upd.lead_zero = (ch == CH_ZERO);
            upd.fval    = dec_accum(st.fval, ch);
            upd.dig_cnt = dig_inc(st.dig_cnt);
          end
          if (st.pend_cnt != PEND_SAT) upd.pend_cnt = PEND_W'(st.pend_cnt + 1'b1);
        end
      end
    endcase
  end

  always_comb begin
    kind = KIND_NONE;
    if (!upd.failed) begin
      if (upd.mode == MODE_V6) begin
        if ((upd.sep_cnt == V6_SEPS) && (upd.dig_cnt != '0) && (upd.dig_cnt <= V6_DIG_MAX))
          kind = KIND_V6;
      end else if (upd.mode == MODE_V4) begin
        if ((upd.sep_cnt == V4_SEPS) && v4_ok(upd))
          kind = KIND_V4;
      end
    end
  end

  // the last word of a string restarts the parser
  assign st_nxt = last ? ST_RESET : upd;

endmodule

>>> design/ip_address_text_validator.sv
// Top level: input word register, parser state and verdict register.
// A last word passes the input word register and then the verdict register before
// its verdict shows on out_kind.
// Throughput: one word per cycle while in_stall is low; the parser update is one pass of ipv_step logic.
// The input register keeps taking words while a verdict waits on out_stall,
// as long as the waiting word is not itself a last word.
// Reset (rst_n low, synchronous): both valid flags clear and the parser returns
// to its start state, undecided type with no fields seen.
module ip_address_text_validator
  import ipv_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CH_W-1:0]   in_ch,
  input  logic              in_last,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [KIND_W-1:0] out_kind
);

  // input stage
  logic              s1_valid_r;
  logic [CH_W-1:0]   s1_ch_r;
  logic              s1_last_r;

  // parser state and verdict register
  ipv_state_t        st_r;
  ipv_state_t        st_nxt;
  logic [KIND_W-1:0] kind_nxt;
  logic              out_valid_r;
  logic [KIND_W-1:0] out_kind_r;

  logic              adv;

  // A word moves into the parser unless it is a last word and the verdict
  // slot is still held by the sink.
  assign adv      = s1_valid_r && (!s1_last_r || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !adv;

  ipv_step u_step (
    .st     (st_r),
    .ch     (s1_ch_r),
    .last   (s1_last_r),
    .st_nxt (st_nxt),
    .kind   (kind_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
    if (!in_stall && in_valid) begin
      s1_ch_r   <= in_ch;
      s1_last_r <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_RESET;
    end else if (adv) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (adv && s1_last_r) begin
      out_kind_r <= kind_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;

  // a verdict appears only after a last word went through the parser
  a_verdict_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(adv && s1_last_r))
    else $error("verdict raised without a last word");

  // parser restarts after every last word
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_last_r) |=> (st_r == ST_RESET))
    else $error("parser state not cleared after last word");

  // a pending verdict is never overwritten while held
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_kind_r)))
    else $error("held verdict changed");

  // verdict code is a defined kind
  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_kind_r == KIND_NONE) || (out_kind_r == KIND_V4) ||
                     (out_kind_r == KIND_V6)))
    else $error("undefined verdict code");

  // input backpressure only when a last word is blocked by a held verdict
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && s1_last_r && out_valid_r && out_stall))
    else $error("spurious input stall");

endmodule
